// ===== sv/rgbw_pkg.sv =====
// Shared types and constants for the RGBW bit-plane pixel writer.
// No dependencies; imported by rgbw_scale_unit and the top level.
package rgbw_pkg;

  // Slot words per LED: 4 colours of 8 bits
  localparam int unsigned SlotBits = 32;
  // GPIO bit that carries strip row 0
  localparam int unsigned GpioBase = 12;

  // Configuration register indexes
  localparam logic [1:0] REG_FLOOR   = 2'd0;
  localparam logic [1:0] REG_CEILING = 2'd1;
  localparam logic [1:0] REG_BRIGHT  = 2'd2;

  // Item opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Colour shaping settings, handed to the scale unit as one group
  typedef struct packed {
    logic [7:0] floor_lvl;
    logic [7:0] ceiling_lvl;
    logic [7:0] bright_lvl;
  } shape_cfg_t;

endpackage

// ===== sv/rgbw_scale_unit.sv =====
// Shared colour scaler: clamp, multiply by brightness, divide by 255.
// Depends on rgbw_pkg (shape_cfg_t).
module rgbw_scale_unit (
  input  logic               clk_i,
  input  logic               load_i,
  input  logic [7:0]         level_i,
  input  rgbw_pkg::shape_cfg_t cfg_i,
  output logic [7:0]         scaled_o
);
  import rgbw_pkg::*;

  logic [7:0]  ceil_lvl;
  logic [7:0]  clamp_lvl;
  logic [15:0] prod_q;
  logic [15:0] prod_d;
  logic [15:0] recip_sum;

  // Clamp to the ceiling first, then raise to the floor
  always_comb begin
    ceil_lvl  = (level_i > cfg_i.ceiling_lvl) ? cfg_i.ceiling_lvl : level_i;
    clamp_lvl = (ceil_lvl < cfg_i.floor_lvl) ? cfg_i.floor_lvl : ceil_lvl;
    prod_d    = 16'(clamp_lvl) * 16'(cfg_i.bright_lvl);
  end

  // Hold the product for the divide stage
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= prod_d;
    end
  end

  // Exact floor(p / 255) for p up to 255*255: (p + (p >> 8) + 1) >> 8
  assign recip_sum = prod_q + 16'(prod_q[15:8]) + 16'd1;
  assign scaled_o  = recip_sum[15:8];

endmodule

// ===== sv/rgbw_bitplane_pixel_writer_top.sv =====
// Top level of the RGBW bit-plane pixel writer: sequencer and slot-word store.
// Depends on rgbw_pkg and rgbw_scale_unit.
//
//  channel | signals                                   | direction
//  cfg     | cfg_we_i, cfg_idx_i, cfg_data_i           | in, write only
//  in      | in_valid_i/in_ready_o, opcode_i .. slot_* | in
//  out     | out_valid_o/out_ready_i, gpio_word_o, ... | out
//
// A pixel write runs four colours through the shared scaler (one colour per
// cycle), then read-modify-writes the LED's 32 slot words via the store's
// separate read and write ports. A rejected item goes straight to the finish.
// After reset a clearing pass writes zero to all LEDS*32 slot words,
// one per cycle, before the first item is taken.
// A result waits in the output register while the next item is taken.
module rgbw_bitplane_pixel_writer_top #(
  parameter int LEDS = 64,
  parameter int ROWS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [2:0]  strip_row_i,
  input  logic [9:0]  led_column_i,
  input  logic [7:0]  red_level_i,
  input  logic [7:0]  green_level_i,
  input  logic [7:0]  blue_level_i,
  input  logic [7:0]  white_level_i,
  input  logic [14:0] slot_address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] gpio_word_o,
  output logic        rejected_o
);
  import rgbw_pkg::*;

  localparam int Depth = LEDS * SlotBits;
  localparam int Aw    = $clog2(Depth);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLEAR = 3'd1;
  localparam logic [2:0] ST_SCALE = 3'd2;
  localparam logic [2:0] ST_RMW   = 3'd3;
  localparam logic [2:0] ST_RD    = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [5:0]       cnt_q, cnt_d;
  logic [Aw-1:0]    clr_q, clr_d;
  shape_cfg_t       cfg_q;
  logic             out_valid_q, out_valid_d;
  logic [31:0]      gpio_q;
  logic             rejected_q;

  logic             op_q;
  logic             rej_q;
  logic [9:0]       col_q;
  logic [ROWS-1:0]  mask_q;
  logic [Aw-1:0]    addr_q;
  logic [3:0][7:0]  lvl_q;
  logic [31:0]      stream_q;
  logic [Aw-1:0]    waddr_q;

  logic             accept;
  logic             row_ok, col_ok, addr_ok, rej_new;
  logic             out_load;
  logic             scale_load;
  logic [7:0]       scaled;
  logic [14:0]      slot_full;

  logic             mem_we, mem_re;
  logic [Aw-1:0]    mem_waddr, mem_raddr;
  logic [ROWS-1:0]  mem_wdata;
  logic [ROWS-1:0]  mem_q [Depth];
  logic [ROWS-1:0]  rdata_q;

  // Range checks on the incoming beat
  assign row_ok  = {1'b0, strip_row_i} < 4'(ROWS);
  assign col_ok  = {1'b0, led_column_i} < 11'(LEDS);
  assign addr_ok = {1'b0, slot_address_i} < 16'(Depth);
  assign rej_new = (opcode_i == OP_WRITE) ? !(row_ok && col_ok) : !addr_ok;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);
  assign scale_load = (state_q == ST_SCALE) && !cnt_q[2];
  assign slot_full  = {col_q, cnt_q[4:0]};

  // Shared clamp-and-scale unit, one colour per cycle
  rgbw_scale_unit u_scale (
    .clk_i    (clk_i),
    .load_i   (scale_load),
    .level_i  (lvl_q[cnt_q[1:0]]),
    .cfg_i    (cfg_q),
    .scaled_o (scaled)
  );

  // Sequencer and store port selection
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = waddr_q;
    mem_raddr   = slot_full[Aw-1:0];
    mem_wdata   = (rdata_q & ~mask_q) | (stream_q[31] ? mask_q : '0);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + Aw'(1);
        if (clr_q == Aw'(Depth - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cnt_d = '0;
          if (rej_new) begin
            state_d = ST_FIN;
          end else if (opcode_i == OP_WRITE) begin
            state_d = ST_SCALE;
          end else begin
            state_d = ST_RD;
          end
        end
      end
      ST_SCALE: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd4) begin
          cnt_d   = '0;
          state_d = ST_RMW;
        end
      end
      ST_RMW: begin
        mem_re = !cnt_q[5];
        mem_we = (cnt_q != 6'd0);
        cnt_d  = cnt_q + 6'd1;
        if (cnt_q[5]) begin
          state_d = ST_FIN;
        end
      end
      ST_RD: begin
        mem_re    = 1'b1;
        mem_raddr = addr_q;
        state_d   = ST_FIN;
      end
      ST_FIN: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= ST_CLEAR;
      cnt_q             <= '0;
      clr_q             <= '0;
      out_valid_q       <= 1'b0;
      cfg_q.floor_lvl   <= 8'd0;
      cfg_q.ceiling_lvl <= 8'd255;
      cfg_q.bright_lvl  <= 8'd255;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_FLOOR:   cfg_q.floor_lvl   <= cfg_data_i;
          REG_CEILING: cfg_q.ceiling_lvl <= cfg_data_i;
          REG_BRIGHT:  cfg_q.bright_lvl  <= cfg_data_i;
          default:     ;
        endcase
      end
    end
  end

  // Item payload, colour stream and result registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= opcode_i;
      rej_q  <= rej_new;
      col_q  <= led_column_i;
      mask_q <= ROWS'(1) << strip_row_i;
      addr_q <= slot_address_i[Aw-1:0];
      lvl_q  <= {white_level_i, blue_level_i, red_level_i, green_level_i};
    end
    // Shift in scaled colours green first, then shift out one bit per store write
    if (state_q == ST_SCALE && cnt_q != 6'd0) begin
      stream_q <= {stream_q[23:0], scaled};
    end else if (mem_we && state_q == ST_RMW) begin
      stream_q <= {stream_q[30:0], 1'b0};
    end
    waddr_q <= mem_raddr;
    if (out_load) begin
      rejected_q <= rej_q;
      gpio_q     <= (op_q == OP_READ && !rej_q) ? (32'(rdata_q) << GpioBase) : 32'd0;
    end
  end

  // Slot-word store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign gpio_word_o = gpio_q;
  assign rejected_o  = rejected_q;

`ifndef SYNTHESIS
  // The store is written only by the clearing pass or a pixel update
  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_CLEAR || state_q == ST_RMW))
    else $error("store written outside clear or update");

  // A pixel update leaves only after all 32 slot words are written
  a_rmw_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RMW && state_d != ST_RMW) |-> cnt_q == 6'd32)
    else $error("pixel update cut short");

  // A new result appears only from the finish step
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_FIN)
    else $error("result raised outside finish step");

  // A rejected item never touches the store
  a_rej_nowr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && rej_new) |=> (state_q == ST_FIN && !mem_we))
    else $error("rejected item went on to the store");
`endif

endmodule
